// File: design/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants for the hashed tile cache
// Beat payloads, slot entry layout and controller-to-datapath commands.
// ----------------------------------------------------------------------------
package htc_pkg;

  // Slot count must stay a power of two: the slot index is the hash's low bits.
  localparam int unsigned SLOT_COUNT  = 64;
  localparam int unsigned IDX_W       = $clog2(SLOT_COUNT);
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned PORT_HANDLE_W = 16;

  localparam int unsigned MULT_Y     = 31;
  localparam int unsigned MULT_ZOOM  = 415;
  localparam int unsigned MULT_LAYER = 926;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] tile_x;
    logic [31:0] tile_y;
    logic [4:0]  zoom_level;
    logic [1:0]  map_layer;
    logic [15:0] tile_handle;
  } htc_in_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] found_handle;
    logic        evicted;
    logic [15:0] evicted_handle;
  } htc_out_t;

  typedef struct packed {
    logic [31:0]            x_tag;
    logic [31:0]            y_tag;
    logic [6:0]             zl_tag;
    logic [HANDLE_BITS-1:0] handle;
  } htc_entry_t;

  // Per-cycle commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request beat
    logic hash;     // register the slot index
    logic read;     // read the slot and its valid bit
    logic commit;   // compare, update slot, drive the result beat
  } htc_ctl_t;

endpackage

// File: design/htc_ctrl.sv
// ----------------------------------------------------------------------------
// htc_ctrl: request sequencer
// One-hot FSM stepping each request through hash, read and commit.
// ----------------------------------------------------------------------------
module htc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output htc_pkg::htc_ctl_t ctl
);
  import htc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HASH = 4'b0010,
    ST_READ = 4'b0100,
    ST_CMP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_HASH;
      ST_HASH: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign ctl.capture = (state_r == ST_IDLE) && start;
  assign ctl.hash    = (state_r == ST_HASH);
  assign ctl.read    = (state_r == ST_READ);
  assign ctl.commit  = (state_r == ST_CMP);

endmodule

// File: design/htc_datapath.sv
// ----------------------------------------------------------------------------
// htc_datapath: hash, slot memory and tag compare
// Holds the request, the slot array with its valid bits and the result beat.
// ----------------------------------------------------------------------------
module htc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  htc_pkg::htc_ctl_t ctl,
  input  htc_pkg::htc_in_t  in_req,
  output logic              out_valid,
  output htc_pkg::htc_out_t out_res
);
  import htc_pkg::*;

  htc_in_t                req_r;
  logic [IDX_W-1:0]       idx_r;
  htc_entry_t             mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  valid_r;
  htc_entry_t             rd_r;
  logic                   rd_valid_r;
  htc_out_t               res_r, res_nxt;
  logic                   out_valid_r;

  logic [31:0]            hash;
  logic [6:0]             zl;
  logic                   tag_match;
  htc_entry_t             wr_entry;

  // y*31 as a shift and subtract; zoom and layer products are narrow
  assign hash = req_r.tile_x
              + (req_r.tile_y << 5) - req_r.tile_y
              + (32'(req_r.zoom_level) * 32'(MULT_ZOOM))
              + (32'(req_r.map_layer) * 32'(MULT_LAYER));
  assign zl = {req_r.zoom_level, req_r.map_layer};

  assign tag_match = rd_valid_r
                  && (rd_r.x_tag == req_r.tile_x)
                  && (rd_r.y_tag == req_r.tile_y)
                  && (rd_r.zl_tag == zl);

  always_comb begin
    wr_entry.x_tag  = req_r.tile_x;
    wr_entry.y_tag  = req_r.tile_y;
    wr_entry.zl_tag = zl;
    wr_entry.handle = HANDLE_BITS'(req_r.tile_handle);
  end

  always_comb begin
    res_nxt = '0;
    unique case (req_r.cmd)
      CMD_LOOKUP: begin
        if (tag_match) begin
          res_nxt.hit          = 1'b1;
          res_nxt.found_handle = PORT_HANDLE_W'(rd_r.handle);
        end
      end
      CMD_INSERT: begin
        if (rd_valid_r && (rd_r.handle != '0)) begin
          res_nxt.evicted        = 1'b1;
          res_nxt.evicted_handle = PORT_HANDLE_W'(rd_r.handle);
        end
      end
      default: res_nxt = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) req_r <= in_req;
    if (ctl.hash)    idx_r <= hash[IDX_W-1:0];
    if (ctl.read) begin
      rd_r       <= mem[idx_r];
      rd_valid_r <= valid_r[idx_r];
    end
    if (ctl.commit) begin
      res_r <= res_nxt;
      if (req_r.cmd == CMD_INSERT) mem[idx_r] <= wr_entry;
    end
  end

  // control state: valid bits and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.commit;
      if (ctl.commit && (req_r.cmd == CMD_INSERT)) valid_r[idx_r] <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// File: design/hashed_tile_cache_core.sv
// ----------------------------------------------------------------------------
// hashed_tile_cache_core: direct-mapped map tile cache
// Lookup or insert of tiles keyed by column, row, zoom and layer.
// ----------------------------------------------------------------------------
//
//  channel   ports                      handshake
//  --------  -------------------------  -------------------------------------
//  request   start, busy, in_req        beat taken when start && !busy
//  result    out_valid, out_res         one-cycle strobe, cannot be stalled
//
//  Each request goes from accept to the result strobe in order: register
//  the request, hash to a slot index, read the slot memory (registered read
//  port), then compare tags and write back. busy drops as the result is
//  registered, so a new beat can be accepted while that result is shown;
//  no new beat is taken while a request is in flight. Synchronous
//  active-low reset clears the FSM, all slot valid bits and the result
//  strobe; no clearing pass is needed.
//
module hashed_tile_cache_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  htc_pkg::htc_in_t  in_req,
  output logic              out_valid,
  output htc_pkg::htc_out_t out_res
);
  import htc_pkg::*;

  htc_ctl_t ctl;

  // sequencer: one request in flight at a time
  htc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // hash, slot memory, compare and result register
  htc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// File: design/htc_checker.sv
// ----------------------------------------------------------------------------
// htc_checker: port-level checks for the tile cache
// Result timing and result field consistency, bound to the top level.
// ----------------------------------------------------------------------------
module htc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input htc_pkg::htc_out_t out_res
);
  import htc_pkg::*;

  // every accepted beat produces its result strobe
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result strobe missing after accepted request");

  // results never come in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a result is either a lookup or an insert outcome, never both
  a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_res.hit && out_res.evicted))
    else $error("hit and evicted both set");

  // a reported eviction carries a non-null handle; no eviction reports null
  a_evict_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.evicted == (out_res.evicted_handle != '0)))
    else $error("evicted flag and evicted handle disagree");

  // a result strobe only rises as a request in flight completes and busy drops
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> busy == 1'b0 && $past(busy, 1))
    else $error("result strobe without a request in flight");

endmodule

bind hashed_tile_cache_core htc_checker u_htc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
